/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

/* design/cifc_pkg.sv */
// ----------------------------------------------------------------------------
// cifc_pkg
// Types and constants shared by the credit flow control endpoint.
// ----------------------------------------------------------------------------
`default_nettype none

package cifc_pkg;

	localparam int COUNT_BITS_DEFAULT = 16;
	localparam int SPACE_BITS         = 16;
	localparam int QUEUE_DEPTH        = 2;

	// command codes
	localparam logic CMD_RX = 1'b0;
	localparam logic CMD_TX = 1'b1;

	// destination codes
	localparam logic DEST_HOST = 1'b0;
	localparam logic DEST_LINK = 1'b1;

	// top nibble that marks a credit byte
	localparam logic [3:0] CREDIT_MARK = 4'hF;

	// classified operation kinds
	localparam logic [1:0] KIND_PASS   = 2'd0;
	localparam logic [1:0] KIND_CREDIT = 2'd1;
	localparam logic [1:0] KIND_TX     = 2'd2;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
		logic       last_of_burst;
	} item_t;

	typedef struct packed {
		logic                  out_valid;
		logic                  out_dest;
		logic [7:0]            out_byte;
		logic                  out_last;
		logic                  tx_refused;
		logic                  credit_seen;
		logic [SPACE_BITS-1:0] space_now;
	} result_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       last;
	} op_t;

endpackage

`default_nettype wire

/* design/inband_credit_flow_control.sv */
// ----------------------------------------------------------------------------
// inband_credit_flow_control
// Serial link endpoint with in-band credit flow control.
// ----------------------------------------------------------------------------
// Usage:
// - item channel (item_valid/item_ready/item): one transaction per byte,
//   either received from the link (cmd RX) or offered for transmit (cmd TX).
// - result channel (result_valid/result_ready/result): exactly one result
//   transaction per item, in order.
// - A received byte with top nibble F is a credit byte: it updates the acked
//   count and recomputes transmit space, and it is dropped from the stream.
// - A transmit offer with no space comes back with tx_refused; resend it.
// - Path: an accepted item is held in the classify register, then in a
//   queue slot, then in the result register, which raises result_valid.
// - Throughput: one item per cycle while result_ready stays high, bounded
//   by the single counter update in the execution stage.
// - Reset clears all counters to zero, so transmits are refused until the
//   first credit byte arrives; queue and result register are emptied.
// - When the receiver stalls, the result register holds, the queue fills,
//   and item_ready drops once the queue and classify stage are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module inband_credit_flow_control import cifc_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_ready,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_ready,
	output result_t    result
);

	logic q_push;
	op_t  q_push_op;
	logic q_full;
	logic q_nonempty;
	op_t  q_head_op;
	logic q_pop;

	// front: accept and classify
	cifc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push       (q_push),
		.push_op    (q_push_op),
		.q_full     (q_full)
	);

	// decouple front from back so each side stalls on its own
	cifc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_op  (q_push_op),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head_op  (q_head_op),
		.pop      (q_pop)
	);

	// back: advance counters and register the result
	cifc_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (q_nonempty),
		.op           (q_head_op),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// never push into a full queue
	`ASSERT_NEVER(a_no_overflow, clk, arst_n, q_push && q_full)
	// a refused transmit always reports zero space
	`ASSERT_IMPLIES(a_refuse_zero, clk, arst_n,
		result_valid && result.tx_refused,
		result.space_now == '0 && !result.out_valid)
	// a consumed credit byte delivers nothing
	`ASSERT_IMPLIES(a_credit_drop, clk, arst_n,
		result_valid && result.credit_seen,
		!result.out_valid && result.out_dest == DEST_HOST)

endmodule

`default_nettype wire

/* design/cifc_front.sv */
// ----------------------------------------------------------------------------
// cifc_front
// Accepts input transactions, classifies them and pushes them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cifc_front import cifc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_ready,
	input  wire item_t item,
	output logic       push,
	output op_t        push_op,
	input  wire logic  q_full
);

	logic valid_s1;
	op_t  op_s1;
	op_t  op_d;

	// classify: credit byte, pass-through byte or transmit offer
	always_comb begin
		op_d.data_byte = item.data_byte;
		op_d.last      = item.last_of_burst;
		if (item.cmd == CMD_TX) begin
			op_d.kind = KIND_TX;
		end else if (item.data_byte[7:4] == CREDIT_MARK) begin
			op_d.kind = KIND_CREDIT;
		end else begin
			op_d.kind = KIND_PASS;
		end
	end

	assign push       = valid_s1 && !q_full;
	assign item_ready = !valid_s1 || !q_full;
	assign push_op    = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			op_s1 <= op_d;
		end
	end

endmodule

`default_nettype wire

/* design/cifc_queue.sv */
// ----------------------------------------------------------------------------
// cifc_queue
// Short register queue between the classifier and the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module cifc_queue import cifc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      full,
	output logic      nonempty,
	output op_t       head_op,
	input  wire logic pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	op_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head_op  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

/* design/cifc_back.sv */
// ----------------------------------------------------------------------------
// cifc_back
// Executes queued operations against the credit counters and registers
// one result per operation.
// ----------------------------------------------------------------------------
`default_nettype none

module cifc_back import cifc_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic op_valid,
	input  wire op_t  op,
	output logic      pop,
	output logic      result_valid,
	input  wire logic result_ready,
	output result_t   result
);

	localparam int HI_BITS = COUNT_BITS - 8;

	logic [COUNT_BITS-1:0] sent_q;
	logic [COUNT_BITS-1:0] acked_q;
	logic [COUNT_BITS-1:0] space_q;
	logic                  rvalid_q;
	result_t               result_q;

	logic [7:0]            lo_new;
	logic                  lo_wrap;
	logic [HI_BITS-1:0]    hi_new;
	logic [COUNT_BITS-1:0] acked_new;
	logic [COUNT_BITS-1:0] space_credit;
	logic [COUNT_BITS-1:0] sent_d;
	logic [COUNT_BITS-1:0] acked_d;
	logic [COUNT_BITS-1:0] space_d;
	result_t               res_d;

	assign pop          = op_valid && (!rvalid_q || result_ready);
	assign result_valid = rvalid_q;
	assign result       = result_q;

	// new acked low byte; advance the high part when the low byte wraps
	assign lo_new       = {op.data_byte[3:0], 4'h0};
	assign lo_wrap      = lo_new < acked_q[7:0];
	assign hi_new       = acked_q[COUNT_BITS-1:8] + HI_BITS'(lo_wrap);
	assign acked_new    = {hi_new, lo_new};
	assign space_credit = acked_new + COUNT_BITS'(8'hFF) - sent_q;

	always_comb begin
		sent_d            = sent_q;
		acked_d           = acked_q;
		space_d           = space_q;
		res_d.out_valid   = 1'b0;
		res_d.out_dest    = DEST_HOST;
		res_d.out_byte    = 8'h00;
		res_d.out_last    = 1'b0;
		res_d.tx_refused  = 1'b0;
		res_d.credit_seen = 1'b0;
		case (op.kind)
			KIND_PASS: begin
				res_d.out_valid = 1'b1;
				res_d.out_byte  = op.data_byte;
				res_d.out_last  = op.last;
			end
			KIND_CREDIT: begin
				acked_d           = acked_new;
				space_d           = space_credit;
				res_d.credit_seen = 1'b1;
			end
			KIND_TX: begin
				res_d.out_dest = DEST_LINK;
				if (space_q != '0) begin
					sent_d          = sent_q + 1'b1;
					space_d         = space_q - 1'b1;
					res_d.out_valid = 1'b1;
					res_d.out_byte  = op.data_byte;
					res_d.out_last  = op.last;
				end else begin
					res_d.tx_refused = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res_d.space_now = SPACE_BITS'(space_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q   <= '0;
			acked_q  <= '0;
			space_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				sent_q  <= sent_d;
				acked_q <= acked_d;
				space_q <= space_d;
			end
			if (pop) begin
				rvalid_q <= 1'b1;
			end else if (result_ready) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res_d;
		end
	end

endmodule

`default_nettype wire
